// ===== hw/rtl/gtc_pkg.sv =====
// Shared types, command codes and time arithmetic helpers for the guest time counter.
package gtc_pkg;

    localparam int TIME_W = 64;
    localparam int BOOT_W = 63;
    localparam int CMD_W  = 3;

    localparam logic [TIME_W-1:0] SIGN_BIT = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [TIME_W-1:0] POS_MAX  = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [TIME_W-1:0] ALL_ONES = {TIME_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_TICK     = 3'd1,
        CMD_ADVANCE  = 3'd2,
        CMD_SET_WALL = 3'd3,
        CMD_RESTART  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0] mono;
        logic [TIME_W-1:0] off;
    } t_time_state;

    // Saturating signed difference cal - mono, as a two's complement pattern.
    function automatic logic [TIME_W-1:0] form_offset(
        input logic [TIME_W-1:0] cal,
        input logic [TIME_W-1:0] mono
    );
        logic [TIME_W:0]   diff;
        logic [TIME_W-1:0] res;
        diff = {1'b0, cal} - {1'b0, mono};
        if (!diff[TIME_W]) begin
            res = diff[TIME_W-1] ? POS_MAX : diff[TIME_W-1:0];
        end else begin
            // negative: magnitude of 2^63 or more pins to the most negative value
            res = diff[TIME_W-1] ? diff[TIME_W-1:0] : SIGN_BIT;
        end
        return res;
    endfunction

    // Counter plus signed offset, clamped to 0 and to the all-ones value.
    function automatic logic [TIME_W-1:0] calendar_from(
        input logic [TIME_W-1:0] mono,
        input logic [TIME_W-1:0] off
    );
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] res;
        sum = {1'b0, mono} + {1'b0, off};
        if (off[TIME_W-1]) begin
            res = sum[TIME_W] ? sum[TIME_W-1:0] : '0;
        end else begin
            res = sum[TIME_W] ? ALL_ONES : sum[TIME_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/gtc_if.sv =====
// Valid/ready channel interfaces for command items and result items.
interface gtc_cmd_if import gtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] operand_value;

    modport source (output valid, output command, output operand_value, input ready);
    modport sink   (input valid, input command, input operand_value, output ready);
endinterface

interface gtc_res_if import gtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] monotonic_now;
    logic [TIME_W-1:0] calendar_now;
    logic [BOOT_W-1:0] boot_instant;

    modport source (output valid, output monotonic_now, output calendar_now,
                    output boot_instant, input ready);
    modport sink   (input valid, input monotonic_now, input calendar_now,
                    input boot_instant, output ready);
endinterface

// ===== hw/rtl/guest_time_counter_with_wall_offset.sv =====
// Guest time counter top level: state registers, result pipeline and configuration register.
// The block takes one command item per clock while ready and returns exactly one result item
// for each, via the stage 1 snapshot and result registers. The rate is set by the update of
// the counter and offset registers: every command needs at most one 64-bit add, compare or
// subtract against the current state, so the state loop is one register with combinational
// next-state logic. The calendar sum and its clamp run in a second stage on a snapshot of the
// updated state, and the result register decouples the output side so a new item is still
// taken while a finished result waits. The epoch register is written through
// i_cfg_we/i_cfg_wdata, only restart commands use it; write it while no items are in flight.
module guest_time_counter_with_wall_offset import gtc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TIME_W-1:0] i_cfg_wdata,
    gtc_cmd_if.sink           i_cmd,
    gtc_res_if.source         o_res
);

    // Architectural state and the epoch register.
    t_time_state       r_state;
    t_time_state       n_state;
    logic [TIME_W-1:0] r_epoch;

    // Stage 1: snapshot of the state after the item's update.
    logic              r_s1_valid;
    t_time_state       r_s1_state;

    // Result register.
    logic              r_out_valid;
    logic [TIME_W-1:0] r_out_mono;
    logic [TIME_W-1:0] r_out_cal;
    logic [BOOT_W-1:0] r_out_boot;

    logic out_free;
    logic s1_move;
    logic s1_free;
    logic accept;

    // Advance a stage when the one after it is empty or draining this cycle.
    assign out_free = !r_out_valid || o_res.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || out_free;
    assign accept   = i_cmd.valid && s1_free;

    assign i_cmd.ready = s1_free;

    gtc_update u_update (
        .i_command (i_cmd.command),
        .i_operand (i_cmd.operand_value),
        .i_epoch   (r_epoch),
        .i_state   (r_state),
        .o_state   (n_state)
    );

    // Commit the update on accept, so the next item sees it in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_epoch <= '0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                r_epoch <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_state <= n_state;
        end
    end

    // Form calendar time and boot instant from the snapshot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_mono <= r_s1_state.mono;
            r_out_cal  <= calendar_from(r_s1_state.mono, r_s1_state.off);
            r_out_boot <= r_s1_state.off[TIME_W-1] ? '0 : r_s1_state.off[BOOT_W-1:0];
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.monotonic_now = r_out_mono;
    assign o_res.calendar_now  = r_out_cal;
    assign o_res.boot_instant  = r_out_boot;

`ifndef SYNTH
    // A read item must leave the state untouched.
    a_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd.command == CMD_READ) |=> $stable(r_state))
        else $error("read item changed the time state");

    // Restart loads the counter with the operand.
    a_restart_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd.command == CMD_RESTART) |=>
            r_state.mono == $past(i_cmd.operand_value))
        else $error("restart did not load the counter");

    // A stalled stage 1 item must block new input.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |-> !i_cmd.ready)
        else $error("input taken while stage 1 is stalled");

    // A positive offset never puts calendar time below the counter.
    a_cal_not_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_boot != '0) |-> r_out_cal >= r_out_mono)
        else $error("calendar time below counter with positive offset");
`endif

endmodule

// ===== hw/rtl/gtc_update.sv =====
// Next-state logic: applies one command to the counter and the calendar offset.
module gtc_update import gtc_pkg::*; (
    input  logic [CMD_W-1:0]  i_command,
    input  logic [TIME_W-1:0] i_operand,
    input  logic [TIME_W-1:0] i_epoch,
    input  t_time_state       i_state,
    output t_time_state       o_state
);

    always_comb begin
        o_state = i_state;
        unique case (i_command)
            CMD_TICK: begin
                o_state.mono = i_state.mono + i_operand;
            end
            CMD_ADVANCE: begin
                if (i_state.mono < i_operand) begin
                    o_state.mono = i_operand;
                end
            end
            CMD_SET_WALL: begin
                o_state.off = form_offset(i_operand, i_state.mono);
            end
            CMD_RESTART: begin
                o_state.mono = i_operand;
                o_state.off  = form_offset(i_epoch, i_operand);
            end
            default: begin
                // read and unused codes: hold
                o_state = i_state;
            end
        endcase
    end

endmodule
